// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the queue RTL; empty bodies when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition must hold on every clock edge out of reset.
`define TCPQ_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// When pre holds, post must hold on the following edge.
`define TCPQ_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define TCPQ_CHECK(label, expr)
`define TCPQ_CHECK_NEXT(label, pre, post)

`endif

`endif

// ----- rtl/tcpq_pkg.sv -----
// Shared constants, codes and controller/datapath types for the queue.
package tcpq_pkg;

  localparam int DEPTH      = 16;
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int TAG_W      = 32;
  localparam int AGE_W      = 8;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // request commands
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // result kinds loaded into the output register
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_HEAD   = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  // register index (word address bit)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [AGE_W-1:0] THRESHOLD_RESET = 8'd60;

  typedef struct packed {
    logic              store_enq;
    logic              store_deq;
    logic              out_load;
    logic [1:0]        out_kind;
    logic [STAT_W-1:0] out_status;
    logic              list_clr;
    logic              list_inc;
  } tcpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic list_final;
  } tcpq_stat_t;

endpackage

// ----- rtl/tcpq_in_if.sv -----
// Request channel: command and new entry fields with valid/ready.
interface tcpq_in_if;
  import tcpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [TAG_W-1:0] entry_tag;
  logic [AGE_W-1:0] entry_age;

  modport source (output valid, command, entry_tag, entry_age, input ready);
  modport sink   (input valid, command, entry_tag, entry_age, output ready);
endinterface

// ----- rtl/tcpq_out_if.sv -----
// Result channel: status, entry fields, position and last marker.
interface tcpq_out_if;
  import tcpq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  out_tag;
  logic [AGE_W-1:0]  out_age;
  logic [POS_W-1:0]  position;
  logic              last;

  modport source (output valid, status, out_tag, out_age, position, last, input ready);
  modport sink   (input valid, status, out_tag, out_age, position, last, output ready);
endinterface

// ----- rtl/tcpq_cfg.sv -----
// APB-style register block holding the priority age threshold.
module tcpq_cfg
  import tcpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [AGE_W-1:0]      threshold
);

  logic [AGE_W-1:0] thr_r, thr_nxt;
  logic             sel_thr;

  assign pready  = 1'b1;
  assign sel_thr = (paddr[2] == REG_THRESHOLD);

  // write on the access phase
  always_comb begin
    thr_nxt = thr_r;
    if (psel && penable && pwrite && sel_thr) begin
      thr_nxt = pwdata[AGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // readback
  assign prdata    = sel_thr ? CFG_DATA_W'(thr_r) : '0;
  assign threshold = thr_r;

endmodule

// ----- rtl/tcpq_ctrl.sv -----
// Controller FSM: decodes requests and sequences list streaming.
module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  tcpq_stat_t       stat,
  output tcpq_cmd_t        cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_kind   = KIND_STATUS;
    cmd.out_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          unique case (in_command)
            CMD_ENQ: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = stat.full ? ST_FULL : ST_OK;
              cmd.store_enq  = !stat.full;
            end
            CMD_DEQ: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.out_kind  = KIND_HEAD;
                cmd.store_deq = 1'b1;
              end
            end
            CMD_LIST: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.list_clr = 1'b1;
                state_nxt    = S_LIST;
              end
            end
            default: begin
              // unused command: dropped
            end
          endcase
        end
      end
      S_LIST: begin
        // one entry per cycle while the output register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_LIST;
          cmd.list_inc = 1'b1;
          if (stat.list_final) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/tcpq_datapath.sv -----
// Datapath: shifting entry row, occupancy counters, list index, output register.
module tcpq_datapath
  import tcpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TAG_W-1:0]  in_tag,
  input  logic [AGE_W-1:0]  in_age,
  input  logic [AGE_W-1:0]  threshold,
  input  tcpq_cmd_t         cmd,
  output tcpq_stat_t        stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [TAG_W-1:0]  out_tag,
  output logic [AGE_W-1:0]  out_age,
  output logic [POS_W-1:0]  out_position,
  output logic              out_last
);

  logic [TAG_W-1:0]  tag_r [DEPTH];
  logic [AGE_W-1:0]  age_r [DEPTH];
  logic [TAG_W-1:0]  tag_nxt [DEPTH];
  logic [AGE_W-1:0]  age_nxt [DEPTH];
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [OCC_W-1:0]  pocc_r, pocc_nxt;
  logic [IDX_W-1:0]  lidx_r, lidx_nxt;
  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] ost_r, ost_nxt;
  logic [TAG_W-1:0]  otag_r, otag_nxt;
  logic [AGE_W-1:0]  oage_r, oage_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic              olast_r, olast_nxt;
  logic              is_prio;
  logic [OCC_W-1:0]  ins;

  // status to the controller
  assign stat.full       = (occ_r == OCC_W'(DEPTH));
  assign stat.empty      = (occ_r == '0);
  assign stat.out_free   = !ov_r || out_ready;
  assign stat.list_final = ((OCC_W'(lidx_r) + OCC_W'(1)) == occ_r);

  // insert point: after the priority run, or at the tail
  assign is_prio = (in_age >= threshold);
  always_comb begin
    ins = occ_r;
    if (is_prio) begin
      ins = (pocc_r > occ_r) ? occ_r : pocc_r;
    end
  end

  // entry row: shift toward tail on enqueue, toward head on dequeue
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tag_nxt[i] = tag_r[i];
      age_nxt[i] = age_r[i];
      if (cmd.store_enq) begin
        if (OCC_W'(i) == ins) begin
          tag_nxt[i] = in_tag;
          age_nxt[i] = in_age;
        end else if (i > 0 && OCC_W'(i) > ins) begin
          tag_nxt[i] = tag_r[(i > 0) ? i - 1 : 0];
          age_nxt[i] = age_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.store_deq && i < DEPTH - 1) begin
        tag_nxt[i] = tag_r[(i < DEPTH - 1) ? i + 1 : i];
        age_nxt[i] = age_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // counters
  always_comb begin
    occ_nxt  = occ_r;
    pocc_nxt = pocc_r;
    lidx_nxt = lidx_r;
    if (cmd.store_enq) begin
      occ_nxt = occ_r + OCC_W'(1);
      if (is_prio) begin
        pocc_nxt = ins + OCC_W'(1);
      end
    end else if (cmd.store_deq) begin
      occ_nxt = occ_r - OCC_W'(1);
      if (pocc_r != '0) begin
        pocc_nxt = pocc_r - OCC_W'(1);
      end
    end
    if (cmd.list_clr) begin
      lidx_nxt = '0;
    end else if (cmd.list_inc) begin
      lidx_nxt = lidx_r + IDX_W'(1);
    end
  end

  // output register
  always_comb begin
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    otag_nxt  = otag_r;
    oage_nxt  = oage_r;
    opos_nxt  = opos_r;
    olast_nxt = olast_r;
    if (cmd.out_load) begin
      ov_nxt    = 1'b1;
      ost_nxt   = cmd.out_status;
      otag_nxt  = '0;
      oage_nxt  = '0;
      opos_nxt  = '0;
      olast_nxt = 1'b1;
      unique case (cmd.out_kind)
        KIND_HEAD: begin
          otag_nxt = tag_r[0];
          oage_nxt = age_r[0];
        end
        KIND_LIST: begin
          otag_nxt  = tag_r[lidx_r];
          oage_nxt  = age_r[lidx_r];
          opos_nxt  = POS_W'(lidx_r) + POS_W'(1);
          olast_nxt = stat.list_final;
        end
        default: begin
          // status-only result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      pocc_r <= '0;
      lidx_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      pocc_r <= pocc_nxt;
      lidx_r <= lidx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    age_r   <= age_nxt;
    ost_r   <= ost_nxt;
    otag_r  <= otag_nxt;
    oage_r  <= oage_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_tag      = otag_r;
  assign out_age      = oage_r;
  assign out_position = opos_r;
  assign out_last     = olast_r;

endmodule

// ----- rtl/two_class_priority_queue_core.sv -----
// Enqueue and dequeue requests: taken while the output register is free, result registered.
// List: one result per queued entry, one per cycle while the output register is free;
// the block is busy meanwhile. Other requests are taken as the previous result leaves.
// Throughput is set by the single output register and the list index counter.
// Synchronous active-low reset empties the queue, clears the output valid flag,
// and sets the threshold to 60; entry storage is not cleared.
`include "assert_macros.svh"

module two_class_priority_queue_core
  import tcpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tcpq_in_if.sink               in_ch,
  tcpq_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  tcpq_cmd_t        cmd;
  tcpq_stat_t       stat;
  logic [AGE_W-1:0] threshold;
  logic             list_start;

  // configuration register
  tcpq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .threshold (threshold)
  );

  // controller
  tcpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath
  tcpq_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tag       (in_ch.entry_tag),
    .in_age       (in_ch.entry_age),
    .threshold    (threshold),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_tag      (out_ch.out_tag),
    .out_age      (out_ch.out_age),
    .out_position (out_ch.position),
    .out_last     (out_ch.last)
  );

  // list request taken on a non-empty queue
  assign list_start = in_ch.valid && in_ch.ready && (in_ch.command == CMD_LIST) && !stat.empty;

  // checks
  `TCPQ_CHECK(a_no_store_full, !cmd.store_enq || !stat.full)
  `TCPQ_CHECK(a_no_remove_empty, !cmd.store_deq || !stat.empty)
  `TCPQ_CHECK(a_no_result_overwrite, !cmd.out_load || stat.out_free)
  `TCPQ_CHECK_NEXT(a_list_blocks_requests, list_start, !in_ch.ready)

endmodule

// ----- dv/priority_queue_checker.sv -----
// Checker for the two-class priority queue: mirrors the queue and compares every result.
`timescale 1ns / 1ps

module priority_queue_checker
  import tcpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tcpq_in_if                    in_ch,
  tcpq_out_if                   out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    mismatch_count,
  output int                    results_awaited
);

  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
    logic [POS_W-1:0]  position;
    logic              last;
  } queue_result_t;

  // mirror of the queue row, head at index 0
  logic [TAG_W-1:0] row_tag [DEPTH];
  logic [AGE_W-1:0] row_age [DEPTH];
  int               held;
  int               prio_held;
  logic [AGE_W-1:0] age_threshold;
  int               failures = 0;

  queue_result_t    expected_results [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    failures++;
    if (failures <= MAX_PRINTED)
      $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Apply one accepted request to the mirror and queue up the results it causes.
  function automatic void apply_request(input logic [CMD_W-1:0] cmd,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [AGE_W-1:0] age);
    queue_result_t r;
    int ins;
    int i;
    r      = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_ENQ: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          if (age >= age_threshold) begin
            // priority entry goes right behind the priority run
            ins = (prio_held > held) ? held : prio_held;
            for (i = held; i > ins; i--) begin
              row_tag[i] = row_tag[i-1];
              row_age[i] = row_age[i-1];
            end
            prio_held = ins + 1;
          end else begin
            ins = held;
          end
          row_tag[ins] = tag;
          row_age[ins] = age;
          held++;
        end
        expected_results.push_back(r);
      end
      CMD_DEQ: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_OK;
          r.tag    = row_tag[0];
          r.age    = row_age[0];
          for (i = 0; i + 1 < held; i++) begin
            row_tag[i] = row_tag[i+1];
            row_age[i] = row_age[i+1];
          end
          held--;
          if (prio_held > 0) prio_held--;
        end
        expected_results.push_back(r);
      end
      CMD_LIST: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (i = 0; i < held; i++) begin
            r.status   = ST_OK;
            r.tag      = row_tag[i];
            r.age      = row_age[i];
            r.position = POS_W'(i + 1);
            r.last     = (i + 1 == held);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        // unused command: no result, no change
      end
    endcase
  endfunction

  // Sample all channels at the clock edge; results before requests of the same edge.
  always @(posedge clk) begin : watch
    queue_result_t want;
    if (!rst_n) begin
      held          = 0;
      prio_held     = 0;
      age_threshold = THRESHOLD_RESET;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD)
        age_threshold = cfg_pwdata[AGE_W-1:0];

      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", 64'(out_ch.out_tag), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 64'(out_ch.status), 64'(want.status));
          if (out_ch.out_tag !== want.tag)
            report_mismatch("out_tag", 64'(out_ch.out_tag), 64'(want.tag));
          if (out_ch.out_age !== want.age)
            report_mismatch("out_age", 64'(out_ch.out_age), 64'(want.age));
          if (out_ch.position !== want.position)
            report_mismatch("position", 64'(out_ch.position), 64'(want.position));
          if (out_ch.last !== want.last)
            report_mismatch("last", 64'(out_ch.last), 64'(want.last));
        end
      end

      if (in_ch.valid && in_ch.ready)
        apply_request(in_ch.command, in_ch.entry_tag, in_ch.entry_age);
    end
    mismatch_count  <= failures;
    results_awaited <= expected_results.size();
  end

endmodule

// ----- dv/two_class_priority_queue_core_tb.sv -----
// Testbench top for the two-class priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module two_class_priority_queue_core_tb;
  import tcpq_pkg::*;

  localparam int RESET_CYCLES       = 8;
  localparam int RESULT_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES      = 4;
  localparam int STALL_LIMIT        = 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int               mismatch_count;
  int               results_awaited;
  int               hold_asked = 0;
  logic [AGE_W-1:0] threshold_now;

  tcpq_in_if  in_ch ();
  tcpq_out_if out_ch ();

  always #2 clk = ~clk;

  two_class_priority_queue_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  priority_queue_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ages cluster at the extremes and around the current threshold
  function automatic logic [AGE_W-1:0] pick_age();
    int near;
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 8'd255 : 8'd0;
      1: begin
        near = int'(threshold_now) + $urandom_range(4) - 2;
        if (near < 0) near = 0;
        if (near > 255) near = 255;
        return AGE_W'(near);
      end
      default: return AGE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                              input logic [AGE_W-1:0] age, input bit gaps_on);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.entry_tag <= tag;
    in_ch.entry_age <= age;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every pending result has come, then let the block settle.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write; upper data bits carry noise the register ignores.
  task automatic write_threshold(input logic [AGE_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data            = $urandom;
    data[AGE_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_THRESHOLD, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    threshold_now = value;
  endtask

  // Random requests; unused commands are extra noise and are not counted.
  task automatic random_phase(input int count, input int enq_pct, input int deq_pct,
                              input bit gaps_on);
    int sent;
    int roll;
    logic [CMD_W-1:0] cmd;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < enq_pct) cmd = CMD_ENQ;
      else if (roll < enq_pct + deq_pct) cmd = CMD_DEQ;
      else if (roll < 96) cmd = CMD_LIST;
      else cmd = CMD_UNUSED;
      send_request(cmd, $urandom, pick_age(), gaps_on);
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  // Result side: random stalls, runs with no stall, and long hold-offs on demand.
  initial begin : result_sink
    int hold_served;
    int gap;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(7) == 0) begin
        // long run of ready, cut short when a hold-off is asked for
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(60, 20)) begin
          @(posedge clk);
          if (hold_asked != hold_served) break;
        end
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus: reset, directed requests, then random phases under several thresholds.
  initial begin : stimulus
    logic [AGE_W-1:0] fill_ages [16];
    logic [TAG_W-1:0] tag;
    int i;
    fill_ages = '{8'd0, 8'd255, 8'd59, 8'd60, 8'd61, 8'd1, 8'd128, 8'd30,
                  8'd200, 8'd60, 8'd59, 8'd254, 8'd7, 8'd255, 8'd45, 8'd90};
    threshold_now = THRESHOLD_RESET;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_ENQ;
    in_ch.entry_tag <= '0;
    in_ch.entry_age <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: dequeue and list report empty, unused command does nothing
    send_request(CMD_DEQ, $urandom, AGE_W'($urandom_range(255)), 1'b0);
    send_request(CMD_LIST, $urandom, AGE_W'($urandom_range(255)), 1'b0);
    send_request(CMD_UNUSED, $urandom, AGE_W'($urandom_range(255)), 1'b0);

    // fill to capacity with both classes and the tag extremes at the reset threshold
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0:       tag = '0;
        1:       tag = '1;
        2:       tag = 32'hA5A5_A5A5;
        3:       tag = 32'h5A5A_5A5A;
        default: tag = $urandom;
      endcase
      send_request(CMD_ENQ, tag, fill_ages[i], 1'b0);
    end
    // full queue, then list all, dequeue the head, and an ignored command
    send_request(CMD_ENQ, $urandom, 8'd255, 1'b0);
    send_request(CMD_LIST, '0, '0, 1'b0);
    send_request(CMD_DEQ, '0, '0, 1'b0);
    send_request(CMD_UNUSED, '0, '0, 1'b0);
    wait_for_drain();

    // every age is priority; result side holds off while requests keep coming
    write_threshold(8'd0);
    hold_asked <= hold_asked + 1;
    random_phase(30, 50, 20, 1'b0);
    wait_for_drain();

    // only the top age is priority; pause mid-phase until all results are in
    write_threshold(8'd255);
    random_phase(15, 55, 30, 1'b1);
    wait_for_drain();
    random_phase(15, 55, 30, 1'b1);
    wait_for_drain();

    write_threshold(AGE_W'($urandom_range(254, 1)));
    random_phase(30, 45, 40, 1'b1);
    wait_for_drain();

    // reset value again, biased toward filling up
    write_threshold(THRESHOLD_RESET);
    random_phase(30, 70, 15, 1'b0);
    wait_for_drain();

    // biased toward emptying
    write_threshold(8'd1);
    random_phase(20, 30, 55, 1'b1);
    wait_for_drain();

    write_threshold(AGE_W'($urandom_range(255)));
    random_phase(40, 45, 35, 1'b1);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
